// ===== rtl/tlec_pkg.sv =====
`default_nettype none
package tlec_pkg;

  // fixed geometry of the two levels
  localparam int L1_SETS    = 64;
  localparam int L1_WAYS    = 8;
  localparam int L2_SETS    = 512;
  localparam int L2_WAYS    = 16;
  localparam int L1_SET_W   = 6;
  localparam int L2_SET_W   = 9;
  localparam int ADDR_W     = 48;
  localparam int AGE_W      = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 3;

  // largest usable index widths
  localparam logic [2:0] L1_IDX_MAX = 3'd6;
  localparam logic [3:0] L2_IDX_MAX = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_LRU        = 3'd5;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic             l1_hit;
    logic             l2_hit;
    logic             mem_read;
    logic             mem_write;
    logic [CNT_W-1:0] total_mem_reads;
    logic [CNT_W-1:0] total_mem_writes;
    logic [CNT_W-1:0] total_l1_hits;
    logic [CNT_W-1:0] total_l1_misses;
    logic [CNT_W-1:0] total_l2_hits;
    logic [CNT_W-1:0] total_l2_misses;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [AGE_W-1:0]  age;
    logic [ADDR_W-1:0] blk;
  } line_t;

  typedef line_t [L1_WAYS-1:0] l1_row_t;
  typedef line_t [L2_WAYS-1:0] l2_row_t;

  typedef struct packed {
    logic       evict;
    logic [3:0] idx;
  } pick_t;

  // replacement choice over up to 16 ways: first free way, else oldest
  // (lowest way on a tie) through a four-level tree
  function automatic pick_t pick_way(input logic [15:0] vld, input logic [15:0] en,
                                     input logic [15:0][AGE_W-1:0] age);
    logic [15:0]             free;
    logic                    found;
    logic [3:0]              fidx;
    logic [15:0]             cen;
    logic [15:0][AGE_W-1:0]  cage;
    logic [15:0][3:0]        cidx;
    pick_t                   r;
    int                      step;
    free  = ~vld & en;
    found = 1'b0;
    fidx  = '0;
    for (int i = 15; i >= 0; i--) begin
      if (free[i]) begin
        found = 1'b1;
        fidx  = 4'(i);
      end
    end
    cen  = en;
    cage = age;
    for (int i = 0; i < 16; i++) cidx[i] = 4'(i);
    for (int lv = 0; lv < 4; lv++) begin
      step = 1 << lv;
      for (int i = 0; i < 16; i += 2 * step) begin
        if (cen[i+step] && (!cen[i] || (cage[i+step] < cage[i]))) begin
          cen[i]  = 1'b1;
          cage[i] = cage[i+step];
          cidx[i] = cidx[i+step];
        end
      end
    end
    r.evict = !found;
    r.idx   = found ? fidx : cidx[0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tlec_ram.sv =====
`default_nettype none
module tlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/two_level_exclusive_cache_model_unit.sv =====
`default_nettype none
// Two-level exclusive cache model: each read or write transaction is looked
// up in L1 (64 sets x 8 ways) and, on a miss, in L2 (512 sets x 16 ways);
// an L2 hit leaves L2, the line fills L1 and any L1 victim moves to L2.
// Each set lives in one row of a single-port-read RAM per level. An access
// steps through read and lookup states, a pick state on an L1 miss and a
// victim read and place over L2 when a victim moves, then waits in a done
// state for the result slot. After reset a clearing pass sweeps both RAMs
// before the first transaction is taken; the user must make configuration
// writes only when no access is in flight, as the block does not enforce it.
module two_level_exclusive_cache_model_unit
  import tlec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_LOOK, S_PICK, S_VRD, S_VPL, S_DONE
  } state_t;

  state_t state;
  logic [L2_SET_W-1:0] clr_cnt;

  // configuration registers
  logic [3:0] offset_bits;
  logic [2:0] l1_index_bits;
  logic [3:0] l2_index_bits;
  logic [3:0] l1_ways;
  logic [4:0] l2_ways;
  logic       l1_lru;

  // access held while in flight
  logic              act;
  logic [ADDR_W-1:0] addr;
  logic [L1_SET_W-1:0] s1;
  logic [L2_SET_W-1:0] s2;
  logic [ADDR_W-1:0] t1;
  logic [ADDR_W-1:0] t2;
  logic              h1;
  logic              h2;
  logic [ADDR_W-1:0] vblk;
  logic [AGE_W-1:0]  tick;
  logic [5:0][CNT_W-1:0] counts;

  // effective geometry
  logic [2:0] b1;
  logic [3:0] b2;
  logic [15:0] en1;
  logic [15:0] en2;
  logic [3:0] w1;
  logic [4:0] w2;

  assign b1 = (l1_index_bits > L1_IDX_MAX) ? L1_IDX_MAX : l1_index_bits;
  assign b2 = (l2_index_bits > L2_IDX_MAX) ? L2_IDX_MAX : l2_index_bits;
  assign w1 = (l1_ways == 4'd0) ? 4'd1 :
              (l1_ways > 4'(L1_WAYS)) ? 4'(L1_WAYS) : l1_ways;
  assign w2 = (l2_ways == 5'd0) ? 5'd1 :
              (l2_ways > 5'(L2_WAYS)) ? 5'(L2_WAYS) : l2_ways;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      en1[i] = (5'(i) < {1'b0, w1}) && (i < L1_WAYS);
      en2[i] = 5'(i) < w2;
    end
  end

  // address split of the incoming transaction
  logic [ADDR_W-1:0] in_sh;
  logic [L1_SET_W-1:0] in_s1;
  logic [L2_SET_W-1:0] in_s2;
  logic [ADDR_W-1:0] in_t1;
  logic [ADDR_W-1:0] in_t2;

  assign in_sh = in_data.address >> offset_bits;
  assign in_s1 = in_sh[L1_SET_W-1:0] & ~({L1_SET_W{1'b1}} << b1);
  assign in_s2 = in_sh[L2_SET_W-1:0] & ~({L2_SET_W{1'b1}} << b2);
  assign in_t1 = in_data.address >> ({1'b0, offset_bits} + {2'b0, b1});
  assign in_t2 = in_data.address >> ({1'b0, offset_bits} + {1'b0, b2});

  // victim split for the L2 level
  logic [ADDR_W-1:0] v_sh;
  logic [L2_SET_W-1:0] vs;
  logic [ADDR_W-1:0] vt;

  assign v_sh = vblk >> offset_bits;
  assign vs   = v_sh[L2_SET_W-1:0] & ~({L2_SET_W{1'b1}} << b2);
  assign vt   = vblk >> ({1'b0, offset_bits} + {1'b0, b2});

  // set memories
  l1_row_t l1_rdata;
  l1_row_t l1_wdata;
  logic    l1_we;
  logic [L1_SET_W-1:0] l1_waddr;
  l2_row_t l2_rdata;
  l2_row_t l2_wdata;
  logic    l2_we;
  logic [L2_SET_W-1:0] l2_waddr;
  logic [L2_SET_W-1:0] l2_raddr;

  tlec_ram #(.WIDTH($bits(l1_row_t)), .DEPTH(L1_SETS)) u_l1_ram (
    .clk  (clk),
    .we   (l1_we),
    .waddr(l1_waddr),
    .wdata(l1_wdata),
    .raddr(s1),
    .rdata(l1_rdata)
  );

  tlec_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_SETS)) u_l2_ram (
    .clk  (clk),
    .we   (l2_we),
    .waddr(l2_waddr),
    .wdata(l2_wdata),
    .raddr(l2_raddr),
    .rdata(l2_rdata)
  );

  assign l2_raddr = (state == S_VRD || state == S_VPL) ? vs : s2;

  // tag match in both levels
  logic [L1_WAYS-1:0] hv1;
  logic [L2_WAYS-1:0] hv2;
  logic               hit1;
  logic               hit2;
  logic [2:0]         hw1;
  logic [3:0]         hw2;

  always_comb begin
    hit1 = 1'b0;
    hit2 = 1'b0;
    hw1  = '0;
    hw2  = '0;
    for (int i = 0; i < L1_WAYS; i++) begin
      hv1[i] = en1[i] && l1_rdata[i].valid && (l1_rdata[i].tag == t1);
    end
    for (int i = 0; i < L2_WAYS; i++) begin
      hv2[i] = en2[i] && l2_rdata[i].valid && (l2_rdata[i].tag == t2);
    end
    for (int i = L1_WAYS - 1; i >= 0; i--) begin
      if (hv1[i]) begin
        hit1 = 1'b1;
        hw1  = 3'(i);
      end
    end
    for (int i = L2_WAYS - 1; i >= 0; i--) begin
      if (hv2[i]) begin
        hit2 = 1'b1;
        hw2  = 4'(i);
      end
    end
  end

  // replacement choice for each level
  logic [15:0]            v1;
  logic [15:0][AGE_W-1:0] a1;
  logic [15:0]            v2;
  logic [15:0][AGE_W-1:0] a2;
  pick_t                  p1;
  pick_t                  p2;

  always_comb begin
    v1 = '0;
    a1 = '0;
    for (int i = 0; i < L1_WAYS; i++) begin
      v1[i] = l1_rdata[i].valid;
      a1[i] = l1_rdata[i].age;
    end
    for (int i = 0; i < L2_WAYS; i++) begin
      v2[i] = l2_rdata[i].valid;
      a2[i] = l2_rdata[i].age;
    end
    p1 = pick_way(v1, en1, a1);
    p2 = pick_way(v2, en2, a2);
  end

  // memory write ports
  always_comb begin
    l1_we    = 1'b0;
    l1_waddr = s1;
    l1_wdata = l1_rdata;
    l2_we    = 1'b0;
    l2_waddr = s2;
    l2_wdata = l2_rdata;
    case (state)
      S_CLEAR: begin
        l1_we    = 1'b1;
        l1_waddr = clr_cnt[L1_SET_W-1:0];
        l1_wdata = '0;
        l2_we    = 1'b1;
        l2_waddr = clr_cnt;
        l2_wdata = '0;
      end
      S_LOOK: begin
        if (hit1) begin
          l1_we = 1'b1;
          l1_wdata[hw1].blk = addr;
          if (l1_lru) begin
            l1_wdata[hw1].age = tick;
          end
        end else if (hit2) begin
          l2_we = 1'b1;
          l2_wdata[hw2].valid = 1'b0;
        end
      end
      S_PICK: begin
        l1_we = 1'b1;
        l1_wdata[p1.idx[2:0]] = '{valid: 1'b1, tag: t1, age: tick, blk: addr};
      end
      S_VPL: begin
        l2_we    = 1'b1;
        l2_waddr = vs;
        l2_wdata[p2.idx] = '{valid: 1'b1, tag: vt, age: tick, blk: vblk};
      end
      default: begin
      end
    endcase
  end

  // saturating event counters with this transaction counted
  logic [5:0]            ev;
  logic [5:0][CNT_W-1:0] counts_next;

  always_comb begin
    ev[0] = !h1 && !h2;
    ev[1] = act;
    ev[2] = h1;
    ev[3] = !h1;
    ev[4] = h2;
    ev[5] = !h1 && !h2;
    for (int i = 0; i < 6; i++) begin
      counts_next[i] = (ev[i] && counts[i] != CNT_SAT) ? counts[i] + 1'b1 : counts[i];
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      offset_bits   <= 4'd4;
      l1_index_bits <= 3'd4;
      l2_index_bits <= 4'd6;
      l1_ways       <= 4'd2;
      l2_ways       <= 5'd4;
      l1_lru        <= 1'b1;
      tick          <= '0;
      counts        <= '0;
      out_valid     <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET_BITS:   offset_bits   <= cfg_data[3:0];
          CFG_L1_INDEX_BITS: l1_index_bits <= cfg_data[2:0];
          CFG_L2_INDEX_BITS: l2_index_bits <= cfg_data[3:0];
          CFG_L1_WAYS:       l1_ways       <= cfg_data[3:0];
          CFG_L2_WAYS:       l2_ways       <= cfg_data;
          CFG_L1_LRU:        l1_lru        <= cfg_data[0];
          default: begin
          end
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == L2_SET_W'(L2_SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act   <= in_data.action;
            addr  <= in_data.address;
            s1    <= in_s1;
            s2    <= in_s2;
            t1    <= in_t1;
            t2    <= in_t2;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          h1    <= hit1;
          h2    <= !hit1 && hit2;
          state <= hit1 ? S_DONE : S_PICK;
        end
        S_PICK: begin
          vblk  <= l1_rdata[p1.idx[2:0]].blk;
          state <= p1.evict ? S_VRD : S_DONE;
        end
        S_VRD: begin
          state <= S_VPL;
        end
        S_VPL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            counts    <= counts_next;
            tick      <= tick + 1'b1;
            out_valid <= 1'b1;
            out_data  <= '{
              l1_hit:           h1,
              l2_hit:           h2,
              mem_read:         ev[0],
              mem_write:        act,
              total_mem_reads:  counts_next[0],
              total_mem_writes: counts_next[1],
              total_l1_hits:    counts_next[2],
              total_l1_misses:  counts_next[3],
              total_l2_hits:    counts_next[4],
              total_l2_misses:  counts_next[5]
            };
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an L1 hit and an L2 hit never come together
  a_hit_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.l1_hit && out_data.l2_hit))
    else $error("l1 and l2 hit both set");

  // a memory read only on a miss in both levels
  a_read_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mem_read) |-> (!out_data.l1_hit && !out_data.l2_hit))
    else $error("memory read on a hit");

  // a victim is placed only after an L1 miss
  a_victim_after_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_VRD) |-> !h1)
    else $error("victim move after l1 hit");

  // a new result is loaded only when the result slot is free
  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwritten");

endmodule
`default_nettype wire

// ===== bench/tb_two_level_exclusive_cache_model_unit.sv =====
`timescale 1ns / 1ps
module tb_two_level_exclusive_cache_model_unit;
  import tlec_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  two_level_exclusive_cache_model_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the cache state
  logic [3:0] m_offset;
  logic [2:0] m_l1_idx;
  logic [3:0] m_l2_idx;
  logic [3:0] m_l1_ways;
  logic [4:0] m_l2_ways;
  logic m_lru;
  logic l1_vld [L1_SETS*L1_WAYS];
  logic [ADDR_W-1:0] l1_tag [L1_SETS*L1_WAYS];
  logic [AGE_W-1:0] l1_age [L1_SETS*L1_WAYS];
  logic [ADDR_W-1:0] l1_blk [L1_SETS*L1_WAYS];
  logic l2_vld [L2_SETS*L2_WAYS];
  logic [ADDR_W-1:0] l2_tag [L2_SETS*L2_WAYS];
  logic [AGE_W-1:0] l2_age [L2_SETS*L2_WAYS];
  logic [ADDR_W-1:0] l2_blk [L2_SETS*L2_WAYS];
  logic [AGE_W-1:0] tick;
  logic [CNT_W-1:0] n_mrd, n_mwr, n_l1h, n_l1m, n_l2h, n_l2m;

  in_t pending_accesses[$];
  out_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [ADDR_W-1:0] hot_blocks [48];

  function automatic int index_width(input int req, input int cap);
    int k;
    k = 0;
    while (k < req && (2 << k) <= cap) k++;
    return k;
  endfunction

  function automatic int way_count(input int req, input int cap);
    if (req == 0) return 1;
    return (req > cap) ? cap : req;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  // replacement way: first invalid, else smallest age, lowest way on a tie
  function automatic int choose_way(input bit lvl2, input int base, input int ways,
                                    output bit evict);
    int pick;
    pick = 0;
    for (int w = ways - 1; w >= 0; w--)
      if (!(lvl2 ? l2_vld[base+w] : l1_vld[base+w])) pick = w;
    evict = lvl2 ? l2_vld[base+pick] : l1_vld[base+pick];
    if (evict) begin
      for (int w = 1; w < ways; w++) begin
        if (lvl2 ? (l2_age[base+w] < l2_age[base+pick]) : (l1_age[base+w] < l1_age[base+pick]))
          pick = w;
      end
    end
    return pick;
  endfunction

  function automatic out_t cache_access(input in_t acc);
    out_t r;
    int b1, b2, w1, w2, sh, base1, base2, way;
    logic [ADDR_W-1:0] a, t1, t2, victim;
    bit h1, h2, evict, dummy;
    r = '0;
    a = acc.address;
    sh = m_offset;
    b1 = index_width(m_l1_idx, L1_SETS);
    b2 = index_width(m_l2_idx, L2_SETS);
    w1 = way_count(m_l1_ways, L1_WAYS);
    w2 = way_count(m_l2_ways, L2_WAYS);
    base1 = int'((a >> sh) & ((48'd1 << b1) - 1)) * L1_WAYS;
    t1 = a >> (sh + b1);
    h1 = 1'b0;
    h2 = 1'b0;
    for (int w = 0; w < w1; w++) begin
      if (!h1 && l1_vld[base1+w] && l1_tag[base1+w] == t1) begin
        h1 = 1'b1;
        l1_blk[base1+w] = a;
        if (m_lru) l1_age[base1+w] = tick;
      end
    end
    if (h1) begin
      n_l1h = sat_inc(n_l1h);
    end else begin
      n_l1m = sat_inc(n_l1m);
      base2 = int'((a >> sh) & ((48'd1 << b2) - 1)) * L2_WAYS;
      t2 = a >> (sh + b2);
      for (int w = 0; w < w2; w++) begin
        if (!h2 && l2_vld[base2+w] && l2_tag[base2+w] == t2) begin
          h2 = 1'b1;
          l2_vld[base2+w] = 1'b0;
        end
      end
      if (h2) n_l2h = sat_inc(n_l2h);
      else n_l2m = sat_inc(n_l2m);
      // fill L1, the displaced line drops into L2
      way = choose_way(1'b0, base1, w1, evict);
      victim = l1_blk[base1+way];
      l1_vld[base1+way] = 1'b1;
      l1_tag[base1+way] = t1;
      l1_age[base1+way] = tick;
      l1_blk[base1+way] = a;
      if (evict) begin
        base2 = int'((victim >> sh) & ((48'd1 << b2) - 1)) * L2_WAYS;
        way = choose_way(1'b1, base2, w2, dummy);
        l2_vld[base2+way] = 1'b1;
        l2_tag[base2+way] = victim >> (sh + b2);
        l2_age[base2+way] = tick;
        l2_blk[base2+way] = victim;
      end
    end
    r.l1_hit = h1;
    r.l2_hit = h2;
    r.mem_read = !h1 && !h2;
    r.mem_write = acc.action;
    if (r.mem_read) n_mrd = sat_inc(n_mrd);
    if (r.mem_write) n_mwr = sat_inc(n_mwr);
    tick = tick + 1'b1;
    r.total_mem_reads = n_mrd;
    r.total_mem_writes = n_mwr;
    r.total_l1_hits = n_l1h;
    r.total_l1_misses = n_l1m;
    r.total_l2_hits = n_l2h;
    r.total_l2_misses = n_l2m;
    return r;
  endfunction

  // sender: offers queued accesses, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(cache_access(in_data));
      if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_accesses.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // receiver: random stalls, long hold-off on request, field checks
  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, out_data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("l1_hit", e.l1_hit, out_data.l1_hit);
          check_field("l2_hit", e.l2_hit, out_data.l2_hit);
          check_field("mem_read", e.mem_read, out_data.mem_read);
          check_field("mem_write", e.mem_write, out_data.mem_write);
          check_field("total_mem_reads", e.total_mem_reads, out_data.total_mem_reads);
          check_field("total_mem_writes", e.total_mem_writes, out_data.total_mem_writes);
          check_field("total_l1_hits", e.total_l1_hits, out_data.total_l1_hits);
          check_field("total_l1_misses", e.total_l1_misses, out_data.total_l1_misses);
          check_field("total_l2_hits", e.total_l2_hits, out_data.total_l2_hits);
          check_field("total_l2_misses", e.total_l2_misses, out_data.total_l2_misses);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) hold_left--;
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_OFFSET_BITS: m_offset = val[3:0];
      CFG_L1_INDEX_BITS: m_l1_idx = val[2:0];
      CFG_L2_INDEX_BITS: m_l2_idx = val[3:0];
      CFG_L1_WAYS: m_l1_ways = val[3:0];
      CFG_L2_WAYS: m_l2_ways = val[4:0];
      CFG_L1_LRU: m_lru = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int off, input int i1, input int i2, input int w1,
                           input int w2, input int lru);
    write_reg(CFG_OFFSET_BITS, 5'(off));
    write_reg(CFG_L1_INDEX_BITS, 5'(i1));
    write_reg(CFG_L2_INDEX_BITS, 5'(i2));
    write_reg(CFG_L1_WAYS, 5'(w1));
    write_reg(CFG_L2_WAYS, 5'(w2));
    write_reg(CFG_L1_LRU, 5'(lru));
  endtask

  task automatic drain();
    while (pending_accesses.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_access(input bit wr, input logic [ADDR_W-1:0] a);
    in_t t;
    t.action = wr;
    t.address = a;
    pending_accesses.push_back(t);
  endfunction

  // hot blocks crowd into a few sets so that lines get displaced
  function automatic void new_hot_blocks();
    for (int i = 0; i < 48; i++) begin
      hot_blocks[i] = 48'({$urandom, $urandom});
      hot_blocks[i][21:0] = 22'($urandom_range(0, 3) << 14) | 22'($urandom_range(0, 3) << 6);
    end
  endfunction

  function automatic void random_accesses(input int n);
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) a = hot_blocks[$urandom_range(47)] ^ 48'($urandom_range(63));
      else a = 48'({$urandom, $urandom});
      push_access(1'($urandom_range(1)), a);
    end
  endfunction

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 51; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 51; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  initial begin
    for (int i = 0; i < L1_SETS*L1_WAYS; i++) begin
      l1_vld[i] = 0; l1_tag[i] = 0; l1_age[i] = 0; l1_blk[i] = 0;
    end
    for (int i = 0; i < L2_SETS*L2_WAYS; i++) begin
      l2_vld[i] = 0; l2_tag[i] = 0; l2_age[i] = 0; l2_blk[i] = 0;
    end
    tick = 0;
    {n_mrd, n_mwr, n_l1h, n_l1m, n_l2h, n_l2m} = '0;
    m_offset = 4; m_l1_idx = 4; m_l2_idx = 6; m_l1_ways = 2; m_l2_ways = 4; m_lru = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: default geometry, extremes, L1 hit, eviction into L2, L2 hit
    push_access(1'b0, '0);
    push_access(1'b1, '1);
    push_access(1'b0, '0);
    push_access(1'b1, 48'h0000_0000_0008);
    push_access(1'b0, 48'h0000_0000_0100);
    push_access(1'b1, 48'h0000_0000_0200);
    push_access(1'b0, 48'h0000_0000_0000);
    push_access(1'b1, 48'h0000_0000_0300);
    push_access(1'b0, 48'h0000_0000_0400);
    push_access(1'b0, 48'h0000_0000_0100);
    push_access(1'b1, 48'hAAAA_AAAA_AAAA);
    push_access(1'b0, 48'h5555_5555_5555);
    push_access(1'b1, 48'hFFFF_FFFF_FFF0);
    drain();
    // an unused register index is ignored
    write_reg(CFG_UNUSED, 5'd31);
    write_reg(CFG_SPARE, 5'd9);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: configure(0, 0, 0, 1, 1, 0);
        1: configure(12, 6, 9, 8, 16, 1);
        2: configure(15, 7, 15, 15, 31, 1);
        3: configure(0, 0, 0, 0, 0, 0);
        4: configure(4, 2, 3, 2, 3, 0);
        default: configure($urandom_range(15), $urandom_range(7), $urandom_range(15),
                           $urandom_range(15), $urandom_range(31), $urandom_range(1));
      endcase
      set_idling(ph);
      new_hot_blocks();
      random_accesses(90);
      if (ph == 2) begin
        // sender waits for every result before carrying on
        while (pending_accesses.size() > 0 || in_valid || expected_results.size() > 0)
          @(posedge clk);
      end
      if (ph == 1 || ph == 6) long_hold_req = 1'b1;
      random_accesses(90);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
